### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/ymbv_pkg.sv
// ---------------------------------------------------------------------------
// ymbv_pkg
// Item kinds, verdict codes and the CRC-16/XMODEM byte update.
// ---------------------------------------------------------------------------
package ymbv_pkg;

  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0] LAST_GOOD_INIT = 8'hFF;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_IDLE  = 2'd2,
    KIND_RESET = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_GOOD_FIRST  = 3'd0,
    ST_GOOD_RESENT = 3'd1,
    ST_SHORT       = 3'd2,
    ST_EXTRA       = 3'd3,
    ST_CMPL_BAD    = 3'd4,
    ST_SYNC_LOST   = 3'd5,
    ST_BAD_CRC     = 3'd6
  } status_t;

  // One byte into CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### hdl/ymodem_block_validator.sv
// ---------------------------------------------------------------------------
// ymodem_block_validator
// Checks the bytes of a block after SOH and gives one verdict per line idle.
// ---------------------------------------------------------------------------
//  channel | signals                                   | beat
//  item    | item_valid, item_stall, kind, rx_byte,   | one byte or marker
//          | file_open                                 |
//  result  | result_valid, result_stall, status,      | one verdict, only
//          | block_number, block_good, first_time_good,| for line idle
//          | sync_lost, purge_needed                   |
//
// One beat per cycle unless item_stall is high: an input register, then the
// CRC step and verdict logic into the state and the result register. An idle
// beat's verdict passes the input and result registers. The input register
// only holds when a verdict meets a stalled, still-full result register. Sync
// reset returns the block state to zero and the last good number to 255.
module ymodem_block_validator
  import ymbv_pkg::*;
#(
  parameter int CHUNK_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] kind,
  input  logic [7:0] rx_byte,
  input  logic       file_open,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [2:0] status,
  output logic [7:0] block_number,
  output logic       block_good,
  output logic       first_time_good,
  output logic       sync_lost,
  output logic       purge_needed
);

  localparam logic [COUNT_W-1:0] POS_CMPL   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] POS_CRC_HI = COUNT_W'(CHUNK_BYTES + 2);
  localparam logic [COUNT_W-1:0] POS_CRC_LO = COUNT_W'(CHUNK_BYTES + 3);
  localparam logic [COUNT_W-1:0] REST_BYTES = COUNT_W'(CHUNK_BYTES + 4);

  // input register
  logic        s1_valid;
  kind_t       s1_kind;
  logic [7:0]  s1_byte;
  logic        s1_open;
  logic        s1_go;

  // block state
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         number_byte;
  logic [7:0]         complement_byte;
  logic [15:0]        running_crc;
  logic [15:0]        received_crc;
  logic [7:0]         last_good_number;
  logic               sync_lost_flag;

  status_t     verdict;
  logic        first_exp;
  logic        crc_ok;
  logic        purge;

  assign s1_go      = s1_valid && (s1_kind != KIND_IDLE || !result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_go;

  always_comb begin
    first_exp = number_byte == last_good_number + 8'd1;
    crc_ok    = running_crc == received_crc;
    if (byte_count < REST_BYTES) begin
      verdict = ST_SHORT;
    end else if (byte_count > REST_BYTES) begin
      verdict = ST_EXTRA;
    end else if (complement_byte != ~number_byte) begin
      verdict = ST_CMPL_BAD;
    end else if (!first_exp && (!s1_open || number_byte != last_good_number)) begin
      verdict = ST_SYNC_LOST;
    end else if (!crc_ok) begin
      verdict = ST_BAD_CRC;
    end else if (!first_exp) begin
      verdict = ST_GOOD_RESENT;
    end else begin
      verdict = ST_GOOD_FIRST;
    end
    purge = verdict != ST_SHORT && verdict != ST_GOOD_FIRST && verdict != ST_GOOD_RESENT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      s1_kind <= kind_t'(kind);
      s1_byte <= rx_byte;
      s1_open <= file_open;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      number_byte      <= '0;
      complement_byte  <= '0;
      running_crc      <= '0;
      received_crc     <= '0;
      last_good_number <= LAST_GOOD_INIT;
      sync_lost_flag   <= 1'b0;
    end else if (s1_go) begin
      case (s1_kind)
        KIND_START: begin
          byte_count      <= '0;
          number_byte     <= '0;
          complement_byte <= '0;
          running_crc     <= '0;
          received_crc    <= '0;
        end
        KIND_BYTE: begin
          if (byte_count == '0) begin
            number_byte <= s1_byte;
          end else if (byte_count == POS_CMPL) begin
            complement_byte <= s1_byte;
          end else if (byte_count < POS_CRC_HI) begin
            running_crc <= crc16_feed(running_crc, s1_byte);
          end else if (byte_count == POS_CRC_HI) begin
            received_crc[15:8] <= s1_byte;
          end else if (byte_count == POS_CRC_LO) begin
            received_crc[7:0] <= s1_byte;
          end
          if (byte_count != COUNT_MAX) begin
            byte_count <= byte_count + 1'b1;
          end
        end
        KIND_IDLE: begin
          if (verdict == ST_SYNC_LOST) begin
            sync_lost_flag <= 1'b1;
          end
          if (verdict == ST_GOOD_FIRST) begin
            last_good_number <= number_byte;
          end
        end
        KIND_RESET: begin
          last_good_number <= LAST_GOOD_INIT;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_kind == KIND_IDLE) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (s1_go && s1_kind == KIND_IDLE) begin
      status          <= verdict;
      block_number    <= number_byte;
      block_good      <= verdict == ST_GOOD_FIRST || verdict == ST_GOOD_RESENT;
      first_time_good <= verdict == ST_GOOD_FIRST;
      sync_lost       <= sync_lost_flag || verdict == ST_SYNC_LOST;
      purge_needed    <= purge;
    end
  end

endmodule

### hdl/ymbv_checker.sv
// ---------------------------------------------------------------------------
// ymbv_checker
// Port-level checks on the verdict beats of the block validator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ymbv_checker
  import ymbv_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [2:0] status,
  input logic       block_good,
  input logic       first_time_good,
  input logic       sync_lost,
  input logic       purge_needed
);

  logic seen_sync;
  logic res_beat;

  assign res_beat = result_valid && !result_stall;

  // sync loss once delivered must stay set on every later verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_sync <= 1'b0;
    end else if (res_beat && sync_lost) begin
      seen_sync <= 1'b1;
    end
  end

  `ASSERT_IMPLY(a_good_flags, clk, rst, result_valid,
    block_good == (status == ST_GOOD_FIRST || status == ST_GOOD_RESENT) &&
    first_time_good == (status == ST_GOOD_FIRST))
  `ASSERT_IMPLY(a_purge_flag, clk, rst, result_valid,
    purge_needed == (status == ST_EXTRA || status == ST_CMPL_BAD ||
    status == ST_SYNC_LOST || status == ST_BAD_CRC))
  `ASSERT_IMPLY(a_sync_status, clk, rst, result_valid && status == ST_SYNC_LOST, sync_lost)
  `ASSERT_IMPLY(a_sync_sticky, clk, rst, result_valid && seen_sync, sync_lost)
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(status) && $stable(sync_lost))

endmodule

bind ymodem_block_validator ymbv_checker u_ymbv_checker (.*);

### bench/ymodem_block_validator_tb.sv
// ---------------------------------------------------------------------------
// ymodem_block_validator_tb
// Drives byte, start, idle and reset beats into the block validator and
// checks every verdict against an in-bench prediction of the block state:
// byte count, number and complement, running CRC-16, received CRC, last good
// number and the sticky sync-loss flag. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module ymodem_block_validator_tb;
  import ymbv_pkg::*;

  localparam int CHUNK = 128;
  localparam int REST = CHUNK + 4;
  localparam int ITEM_TARGET = 550;
  localparam int TAIL_CYCLES = 10;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    status_t    st;
    logic [7:0] number;
    logic       good;
    logic       first_good;
    logic       sync;
    logic       purge;
  } verdict_t;

  // Tracks the block state and queues the verdict each idle beat should give.
  class verdict_scoreboard;
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         number_byte;
    logic [7:0]         complement_byte;
    logic [15:0]        running_crc;
    logic [15:0]        received_crc;
    logic [7:0]         last_good;
    logic               sync_flag;
    verdict_t           expected_q[$];
    int                 errors;

    function new();
      clear_block();
      last_good = LAST_GOOD_INIT;
      sync_flag = 1'b0;
      errors = 0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
        if (r[15] ^ b[i]) r = {r[14:0], 1'b0} ^ CRC_POLY;
        else r = {r[14:0], 1'b0};
      end
      return r;
    endfunction

    function void clear_block();
      byte_count = '0;
      number_byte = '0;
      complement_byte = '0;
      running_crc = '0;
      received_crc = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(kind_t k, logic [7:0] b, logic fo);
      verdict_t v;
      logic     next_ok;
      case (k)
        KIND_START: clear_block();
        KIND_BYTE: begin
          if (byte_count == 0) number_byte = b;
          else if (byte_count == 1) complement_byte = b;
          else if (byte_count < CHUNK + 2) running_crc = crc_step(running_crc, b);
          else if (byte_count == CHUNK + 2) received_crc[15:8] = b;
          else if (byte_count == CHUNK + 3) received_crc[7:0] = b;
          if (byte_count != COUNT_MAX) byte_count++;
        end
        KIND_RESET: last_good = LAST_GOOD_INIT;
        default: begin
          v.purge = 1'b1;
          if (byte_count < REST) begin
            v.st = ST_SHORT;
            v.purge = 1'b0;
          end else if (byte_count > REST) begin
            v.st = ST_EXTRA;
          end else if (complement_byte != ~number_byte) begin
            v.st = ST_CMPL_BAD;
          end else begin
            next_ok = (number_byte == last_good + 8'd1);
            if (!next_ok && (!fo || number_byte != last_good)) begin
              sync_flag = 1'b1;
              v.st = ST_SYNC_LOST;
            end else if (running_crc != received_crc) begin
              v.st = ST_BAD_CRC;
            end else if (!next_ok) begin
              v.st = ST_GOOD_RESENT;
              v.purge = 1'b0;
            end else begin
              v.st = ST_GOOD_FIRST;
              v.purge = 1'b0;
              last_good = number_byte;
            end
          end
          v.number = number_byte;
          v.good = (v.st == ST_GOOD_FIRST) || (v.st == ST_GOOD_RESENT);
          v.first_good = (v.st == ST_GOOD_FIRST);
          v.sync = sync_flag;
          expected_q.push_back(v);
        end
      endcase
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (expected_q.size() == 0) begin
        $error("verdict with none expected: status %0d, number %0d", got.st, got.number);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("status", want.st, got.st);
      check_field("block_number", want.number, got.number);
      check_field("block_good", want.good, got.good);
      check_field("first_time_good", want.first_good, got.first_good);
      check_field("sync_lost", want.sync, got.sync);
      check_field("purge_needed", want.purge, got.purge);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic       file_open;
  logic       result_valid;
  logic       result_stall;
  logic [2:0] status;
  logic [7:0] block_number;
  logic       block_good;
  logic       first_time_good;
  logic       sync_lost;
  logic       purge_needed;

  verdict_scoreboard sb = new();
  int idle_pct = 11;
  int hold_left = 0;
  int items_sent = 0;

  ymodem_block_validator #(.CHUNK_BYTES(CHUNK)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .rx_byte(rx_byte),
    .file_open(file_open),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .block_number(block_number),
    .block_good(block_good),
    .first_time_good(first_time_good),
    .sync_lost(sync_lost),
    .purge_needed(purge_needed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Accepted beats feed the predictor; accepted verdicts are checked.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      sb.note_item(kind_t'(kind), rx_byte, file_open);
    end
    if (!rst && result_valid && !result_stall) begin
      sb.check_result('{status_t'(status), block_number, block_good, first_time_good,
                        sync_lost, purge_needed});
    end
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  initial begin : receiver
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[ymodem_block_validator] ERROR");
    $finish;
  end

  // Leaves valid high on return so the next beat can follow in the same step.
  task automatic send_item(input kind_t k, input logic [7:0] b, input logic fo);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    rx_byte <= b;
    file_open <= fo;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // Start, number, complement, chunk, CRC (optionally broken), then idle beats.
  // A negative len_delta trims bytes off the end, a positive one appends extras.
  task automatic send_block(input logic [7:0] num, input bit cmpl_ok, input bit crc_ok,
                            input int len_delta, input logic fo, input int idles);
    logic [7:0]  bytes_q[$];
    logic [15:0] crc;
    logic [7:0]  d;
    crc = '0;
    bytes_q.push_back(num);
    bytes_q.push_back(cmpl_ok ? ~num : (~num ^ 8'($urandom_range(1, 255))));
    for (int i = 0; i < CHUNK; i++) begin
      d = 8'($urandom);
      bytes_q.push_back(d);
      crc = verdict_scoreboard::crc_step(crc, d);
    end
    if (!crc_ok) crc ^= 16'($urandom_range(1, 65535));
    bytes_q.push_back(crc[15:8]);
    bytes_q.push_back(crc[7:0]);
    for (int i = 0; i < len_delta; i++) bytes_q.push_back(8'($urandom));
    for (int i = 0; i < -len_delta && bytes_q.size() != 0; i++) void'(bytes_q.pop_back());
    send_item(KIND_START, 8'($urandom), 1'($urandom));
    foreach (bytes_q[i]) send_item(KIND_BYTE, bytes_q[i], 1'($urandom));
    repeat (idles) send_item(KIND_IDLE, 8'($urandom), fo);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic hold_receiver(input int n);
    item_valid <= 1'b0;
    @(negedge clk);
    hold_left = n;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int          iter;
    int          r;
    logic [7:0]  num;
    rst = 1'b1;
    item_valid = 1'b0;
    kind = KIND_START;
    rx_byte = '0;
    file_open = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle before any byte, bytes without a start, repeated idle, field extremes
    send_item(KIND_IDLE, 8'hFF, 1'b0);
    send_item(KIND_BYTE, 8'hFF, 1'b0);
    send_item(KIND_IDLE, 8'h00, 1'b1);
    send_item(KIND_IDLE, 8'hFF, 1'b0);
    send_item(KIND_RESET, 8'h00, 1'b1);
    send_item(KIND_START, 8'hFF, 1'b1);
    send_item(KIND_BYTE, 8'h00, 1'b1);
    send_item(KIND_IDLE, 8'h00, 1'b0);
    send_item(KIND_RESET, 8'hFF, 1'b0);

    // one good block judged over and over as the state around it changes
    send_block(8'h00, 1, 1, 0, 1'b0, 1);   // good, first
    send_item(KIND_IDLE, 8'h00, 1'b1);     // resent
    send_item(KIND_IDLE, 8'h00, 1'b0);     // not next, no file: sync loss
    send_item(KIND_RESET, 8'h5A, 1'b0);
    send_item(KIND_IDLE, 8'hFF, 1'b0);     // next after reset, flag still set
    send_item(KIND_BYTE, 8'h5A, 1'b1);
    send_item(KIND_IDLE, 8'h00, 1'b1);     // one extra byte
    send_block(8'h01, 1, 0, 0, 1'b1, 1);   // bad CRC
    idle_pct = 0;
    send_block(8'h01, 0, 1, 0, 1'b1, 1);   // complement mismatch, no idling
    idle_pct = 11;
    drain();

    // hold results off while idle beats pile up behind a short block
    hold_receiver(100);
    send_block(8'($urandom), 1, 1, -int'($urandom_range(120, 134)), 1'b1, 6);

    iter = 0;
    while (items_sent < ITEM_TARGET && iter < 400) begin
      if (iter % 10 == 9) drain();
      r = $urandom_range(99);
      if (r < 50) begin
        case ($urandom_range(3))
          0, 1: num = sb.last_good + 8'd1;
          2: num = sb.last_good;
          default: num = 8'($urandom);
        endcase
        send_block(num, $urandom_range(99) < 90, $urandom_range(99) < 85,
                   -int'($urandom_range(124, 134)), 1'($urandom),
                   ($urandom_range(99) < 85) ? 1 : 2);
      end else if (r < 60) begin
        send_item(KIND_RESET, 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(kind_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
        end
      end
      iter++;
    end

    item_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d verdicts never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ymodem_block_validator] OK");
    end else begin
      $display("[ymodem_block_validator] ERROR");
    end
    $finish;
  end

endmodule
